[rtl/ofp_pkg.sv]
// Package for the online Pareto frontier block.
// Holds the controller state type, the cell control bundle and fixed field widths.
// No dependencies.
package ofp_pkg;

    localparam int IN_COORD_W = 32;
    localparam int SIZE_W     = 9;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CMP,
        S_DOM,
        S_UPD,
        S_SUM
    } t_state;

    typedef struct packed {
        logic clear;
        logic cmp;
        logic upd;
        logic keep;
    } t_cell_ctl;

endpackage

[rtl/ofp_cell.sv]
// One storage cell of the frontier chain: holds a point and its valid bit.
// Passes the dominance chain and the free-slot token to its right neighbor.
// Depends on ofp_pkg.
module ofp_cell #(
    parameter int COORD_BITS = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  ofp_pkg::t_cell_ctl           i_ctl,
    input  logic signed [COORD_BITS-1:0] i_nx,
    input  logic signed [COORD_BITS-1:0] i_ny,
    input  logic                         i_dom,
    output logic                         o_dom,
    input  logic                         i_tok,
    output logic                         o_tok,
    output logic                         o_valid
);

    logic                         r_valid;
    logic                         r_dom;
    logic                         r_kill;
    logic signed [COORD_BITS-1:0] r_x;
    logic signed [COORD_BITS-1:0] r_y;

    logic w_dom_new;
    logic w_kill_new;
    logic w_free;
    logic w_take;

    always_comb begin
        // stored point dominates the new one
        w_dom_new  = r_valid && (r_x <= i_nx) && (r_y <= i_ny) && ((r_x < i_nx) || (r_y < i_ny));
        // new point dominates the stored one
        w_kill_new = r_valid && (i_nx <= r_x) && (i_ny <= r_y) && ((i_nx < r_x) || (i_ny < r_y));
        w_free     = !r_valid || r_kill;
        w_take     = i_tok && w_free;
    end

    assign o_dom   = i_dom || r_dom;
    assign o_tok   = i_tok && !w_free;
    assign o_valid = r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_dom   <= 1'b0;
            r_kill  <= 1'b0;
        end else begin
            if (i_ctl.clear) begin
                r_valid <= 1'b0;
            end else if (i_ctl.upd && i_ctl.keep) begin
                if (w_take) begin
                    r_valid <= 1'b1;
                end else if (r_kill) begin
                    r_valid <= 1'b0;
                end
            end
            if (i_ctl.cmp) begin
                r_dom  <= w_dom_new;
                r_kill <= w_kill_new;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.upd && i_ctl.keep && w_take) begin
            r_x <= i_nx;
            r_y <= i_ny;
        end
    end

endmodule

[rtl/ofp_popcnt.sv]
// Registered binary adder tree that counts the set bits of a vector.
// One tree level per register stage. No dependencies.
module ofp_popcnt #(
    parameter int N = 256
) (
    input  logic                     i_clk,
    input  logic [N-1:0]             i_bits,
    output logic [$clog2(N+1)-1:0]   o_count
);

    localparam int LVL = $clog2(N);
    localparam int P   = 1 << LVL;
    localparam int CW  = $clog2(N + 1);

    logic [P-1:0]  w_leaf;
    logic [CW-1:0] r_node [1:P-1];

    // pad up to a power of two with zeros
    assign w_leaf = P'(i_bits);

    // heap layout: node k sums nodes 2k and 2k+1, leaves sit at P..2P-1
    for (genvar k = 1; k < P; k++) begin : g_node
        if (2 * k >= P) begin : g_leaf
            always_ff @(posedge i_clk) begin
                r_node[k] <= CW'(w_leaf[2*k-P]) + CW'(w_leaf[2*k+1-P]);
            end
        end else begin : g_inner
            always_ff @(posedge i_clk) begin
                r_node[k] <= r_node[2*k] + r_node[2*k+1];
            end
        end
    end

    assign o_count = r_node[1];

endmodule

[rtl/online_pareto_frontier.sv]
// Online 2-D Pareto frontier (skyline of minima) over CAPACITY point cells. An item is
// compared against every stored point at once in the cell chain, then a dominance chain
// and a free-slot token chain ripple through the cells, and a registered adder tree
// counts the valid cells for frontier_size. An item occupies the block from acceptance
// through the compare, dominance and update steps and the wait on the population-count
// tree; only then, and once the output register is free, can the next item be accepted.
// A finished result waits in that output register, so the next item can be accepted
// while the result is stalled. Coordinates are signed and compared at COORD_BITS.
// Depends on ofp_pkg, ofp_cell and ofp_popcnt.
module online_pareto_frontier #(
    parameter int CAPACITY   = 256,
    parameter int COORD_BITS = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic                                 i_func,
    input  logic signed [ofp_pkg::IN_COORD_W-1:0] i_px,
    input  logic signed [ofp_pkg::IN_COORD_W-1:0] i_py,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic [ofp_pkg::SIZE_W-1:0]           o_frontier_size,
    output logic                                 o_kept,
    output logic                                 o_overflow
);

    localparam int LVL   = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(LVL + 1);
    localparam int CW    = $clog2(CAPACITY + 1);

    ofp_pkg::t_state r_state;
    ofp_pkg::t_state n_state;

    logic signed [COORD_BITS-1:0] w_nx;
    logic signed [COORD_BITS-1:0] w_ny;
    logic signed [COORD_BITS-1:0] r_nx;
    logic signed [COORD_BITS-1:0] r_ny;

    logic                r_keep;
    logic                r_ovf;
    logic [CNT_W-1:0]    r_cnt;
    logic                r_out_valid;
    logic [ofp_pkg::SIZE_W-1:0] r_size;
    logic                r_kept_out;
    logic                r_ovf_out;

    logic                w_accept;
    logic                w_sum_done;
    logic                w_load;
    ofp_pkg::t_cell_ctl  w_ctl;

    logic [CAPACITY:0]   w_dom;
    logic [CAPACITY:0]   w_tok;
    logic [CAPACITY-1:0] w_valid;
    logic [CW-1:0]       w_count;

    // bring the 32-bit inputs to the working coordinate width
    if (COORD_BITS <= ofp_pkg::IN_COORD_W) begin : g_narrow
        assign w_nx = i_px[COORD_BITS-1:0];
        assign w_ny = i_py[COORD_BITS-1:0];
    end else begin : g_wide
        assign w_nx = {{(COORD_BITS-ofp_pkg::IN_COORD_W){i_px[ofp_pkg::IN_COORD_W-1]}}, i_px};
        assign w_ny = {{(COORD_BITS-ofp_pkg::IN_COORD_W){i_py[ofp_pkg::IN_COORD_W-1]}}, i_py};
    end

    assign w_dom[0]   = 1'b0;
    assign w_tok[0]   = r_keep;
    assign w_sum_done = (r_cnt == CNT_W'(LVL));

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        ofp_cell #(
            .COORD_BITS(COORD_BITS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_nx    (r_nx),
            .i_ny    (r_ny),
            .i_dom   (w_dom[g]),
            .o_dom   (w_dom[g+1]),
            .i_tok   (w_tok[g]),
            .o_tok   (w_tok[g+1]),
            .o_valid (w_valid[g])
        );
    end

    ofp_popcnt #(
        .N(CAPACITY)
    ) u_popcnt (
        .i_clk   (i_clk),
        .i_bits  (w_valid),
        .o_count (w_count)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ofp_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = ofp_pkg::S_CMP;
                end
            end
            ofp_pkg::S_CMP: n_state = ofp_pkg::S_DOM;
            ofp_pkg::S_DOM: n_state = ofp_pkg::S_UPD;
            ofp_pkg::S_UPD: n_state = ofp_pkg::S_SUM;
            ofp_pkg::S_SUM: begin
                if (w_sum_done && (!r_out_valid || !i_out_stall)) begin
                    n_state = ofp_pkg::S_IDLE;
                end
            end
            default: n_state = ofp_pkg::S_IDLE;
        endcase
    end

    // controller outputs
    always_comb begin
        o_in_stall  = (r_state != ofp_pkg::S_IDLE);
        w_accept    = i_in_valid && (r_state == ofp_pkg::S_IDLE);
        w_ctl.clear = w_accept && i_func;
        w_ctl.cmp   = (r_state == ofp_pkg::S_CMP);
        w_ctl.upd   = (r_state == ofp_pkg::S_UPD);
        w_ctl.keep  = r_keep;
        w_load      = (r_state == ofp_pkg::S_SUM) && w_sum_done
                      && (!r_out_valid || !i_out_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ofp_pkg::S_IDLE;
            r_keep      <= 1'b0;
            r_ovf       <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ofp_pkg::S_DOM) begin
                r_keep <= !w_dom[CAPACITY];
            end
            if (r_state == ofp_pkg::S_UPD) begin
                // token fell off the end: no free cell for a surviving point
                r_ovf <= r_keep && w_tok[CAPACITY];
            end
            if (r_state != ofp_pkg::S_SUM) begin
                r_cnt <= '0;
            end else if (!w_sum_done) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_nx <= w_nx;
            r_ny <= w_ny;
        end
        if (w_load) begin
            r_size     <= ofp_pkg::SIZE_W'(w_count);
            r_kept_out <= r_keep && !r_ovf;
            r_ovf_out  <= r_ovf;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_frontier_size = r_size;
    assign o_kept          = r_kept_out;
    assign o_overflow      = r_ovf_out;

endmodule

[rtl/ofp_checker.sv]
// Port-level checks for the online Pareto frontier block, bound to its top level.
// Depends on ofp_pkg and online_pareto_frontier.
module ofp_checker #(
    parameter int CAPACITY = 256
) (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 i_in_valid,
    input logic                                 o_in_stall,
    input logic                                 o_out_valid,
    input logic                                 i_out_stall,
    input logic [ofp_pkg::SIZE_W-1:0]           o_frontier_size,
    input logic                                 o_kept,
    input logic                                 o_overflow
);

    // one item at a time: the block is busy right after taking an item
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input not stalled after an item was accepted");

    a_kept_ovf_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_kept && o_overflow))
        else $error("kept and overflow both set");

    // a dropped point on overflow means every cell was occupied
    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_overflow |-> o_frontier_size == ofp_pkg::SIZE_W'(CAPACITY))
        else $error("overflow reported while the store was not full");

    // the 9-bit size cannot wrap to zero while the store stays below 512 entries
    a_kept_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (CAPACITY < 512) && o_out_valid && o_kept |-> o_frontier_size != '0)
        else $error("point kept but frontier size is zero");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_frontier_size)
            && $stable(o_kept) && $stable(o_overflow))
        else $error("stalled result changed");

endmodule

bind online_pareto_frontier ofp_checker #(
    .CAPACITY(CAPACITY)
) u_ofp_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_stall      (o_in_stall),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_frontier_size (o_frontier_size),
    .o_kept          (o_kept),
    .o_overflow      (o_overflow)
);
